// File: src/deq_pkg.sv
package deq_pkg;

    // Request codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } t_state;

    localparam int WORD_W = 32;

endpackage

// File: src/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data; hold it between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/double_ended_queue.sv
// Double-ended queue of 32-bit words in a ring RAM with front/back pointers.
// Each result passes through the RAM read register and the pending registers,
// then into the output register, which loads only while o_valid does not stall.
// Requests are taken one at a time: the next is taken only after that load.
// Reset (synchronous, active low) empties the queue: pointers and count clear,
// RAM contents are left as they are and are never read before being written.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_op,
    input  logic signed [31:0]         i_data_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [31:0]         o_value,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    deq_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;

    // Pending result, waiting for RAM data
    logic            r_pend_rd, n_pend_rd;
    logic [1:0]      r_pend_status, n_pend_status;
    logic [CW-1:0]   r_pend_occ, n_pend_occ;

    // Output register
    logic                    r_o_valid;
    logic signed [31:0]      r_o_value;
    logic [1:0]              r_o_status;
    logic [CW-1:0]           r_o_occ;

    logic                    accept, full, empty, load_out;
    logic [PW-1:0]           head_prev, head_next, tail_prev, tail_next;
    logic                    ram_we, ram_re;
    logic [PW-1:0]           ram_waddr, ram_raddr;
    logic [deq_pkg::WORD_W-1:0] ram_rdata;

    assign o_ready  = (r_state == deq_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign load_out = (r_state == deq_pkg::S_WAIT) && (!r_o_valid || i_ready);

    // Ring neighbours of both pointers
    assign head_prev = (r_head == '0)  ? LAST : r_head - 1'b1;
    assign head_next = (r_head == LAST) ? '0  : r_head + 1'b1;
    assign tail_prev = (r_tail == '0)  ? LAST : r_tail - 1'b1;
    assign tail_next = (r_tail == LAST) ? '0  : r_tail + 1'b1;

    // Decode the request: pointer update and RAM access
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_rd     = r_pend_rd;
        n_pend_status = r_pend_status;
        n_pend_occ    = r_pend_occ;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = r_tail;
        ram_raddr     = r_head;
        if (accept) begin
            n_pend_rd     = 1'b0;
            n_pend_status = deq_pkg::ST_DONE;
            unique case (deq_pkg::t_op'(i_op))
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        n_pend_status = deq_pkg::ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (deq_pkg::t_op'(i_op) == deq_pkg::OP_PUSH_FRONT) begin
                            ram_waddr = head_prev;
                            n_head    = head_prev;
                        end else begin
                            ram_waddr = r_tail;
                            n_tail    = tail_next;
                        end
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
                    if (empty) begin
                        n_pend_status = deq_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        n_pend_rd = 1'b1;
                        ram_raddr = r_head;
                        if (deq_pkg::t_op'(i_op) == deq_pkg::OP_POP_FRONT) begin
                            n_head  = head_next;
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
                    if (empty) begin
                        n_pend_status = deq_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        n_pend_rd = 1'b1;
                        ram_raddr = tail_prev;
                        if (deq_pkg::t_op'(i_op) == deq_pkg::OP_POP_BACK) begin
                            n_tail  = tail_prev;
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    // unused codes leave the queue alone
                end
            endcase
            n_pend_occ = n_count;
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: if (accept)   n_state = deq_pkg::S_WAIT;
            deq_pkg::S_WAIT: if (load_out) n_state = deq_pkg::S_IDLE;
            default:                       n_state = deq_pkg::S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= deq_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Pending and output payload
    always_ff @(posedge i_clk) begin
        r_pend_rd     <= n_pend_rd;
        r_pend_status <= n_pend_status;
        r_pend_occ    <= n_pend_occ;
        if (load_out) begin
            r_o_value  <= r_pend_rd ? $signed(ram_rdata) : 32'sd0;
            r_o_status <= r_pend_status;
            r_o_occ    <= r_pend_occ;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid     = r_o_valid;
    assign o_value     = r_o_value;
    assign o_status    = r_o_status;
    assign o_occupancy = r_o_occ;

    // Count never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy above depth");

    // Empty or full ring has the pointers meeting
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty || full) |-> (r_head == r_tail))
        else $error("pointers apart on empty or full queue");

    // Accepted push to a non-full queue grows the count by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (i_op == 3'(deq_pkg::OP_PUSH_FRONT)
                             || i_op == 3'(deq_pkg::OP_PUSH_BACK)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the count");

    // No new request is taken while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("request taken while previous one pending");

endmodule

// File: bench/double_ended_queue_test.sv
`timescale 1ns / 1ps

module double_ended_queue_test;

    localparam int DEPTH = 16;
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Op codes the block does not decode; they leave the queue unchanged
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_deq_result;

    // Shadow deque: predicts each response and checks it against the block
    class deque_scoreboard;
        logic [31:0]      ring [DEPTH];
        logic [3:0]       front_ptr;
        logic [3:0]       back_ptr;
        logic [OCC_W-1:0] fill;
        t_deq_result      awaited_q [$];
        int unsigned      failures;

        function new();
            front_ptr = '0;
            back_ptr  = '0;
            fill      = '0;
            failures  = 0;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        // Apply one accepted request and queue the response it must give
        function void note_request(logic [2:0] op, logic signed [31:0] word);
            t_deq_result r;
            logic [3:0]  idx;
            r.value  = '0;
            r.status = deq_pkg::ST_DONE;
            case (op)
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                    if (fill == DEPTH) begin
                        r.status = deq_pkg::ST_FULL;
                    end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                        front_ptr = front_ptr - 4'd1;
                        ring[front_ptr] = word;
                        fill = fill + 1'b1;
                    end else begin
                        ring[back_ptr] = word;
                        back_ptr = back_ptr + 4'd1;
                        fill = fill + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                    idx = back_ptr - 4'd1;
                    if (fill == 0) begin
                        r.status = deq_pkg::ST_EMPTY;
                    end else if (op == deq_pkg::OP_POP_FRONT) begin
                        r.value = ring[front_ptr];
                        front_ptr = front_ptr + 4'd1;
                        fill = fill - 1'b1;
                    end else if (op == deq_pkg::OP_POP_BACK) begin
                        back_ptr = idx;
                        r.value = ring[idx];
                        fill = fill - 1'b1;
                    end else if (op == deq_pkg::OP_PEEK_FRONT) begin
                        r.value = ring[front_ptr];
                    end else begin
                        r.value = ring[idx];
                    end
                end
                default: begin
                end
            endcase
            r.occupancy = fill;
            awaited_q.push_back(r);
        endfunction

        // Compare one response with the oldest prediction
        function void check_result(logic signed [31:0] value, logic [1:0] status,
                                   logic [OCC_W-1:0] occupancy);
            t_deq_result e;
            if (awaited_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: response with none awaited: value %0d status %0d occ %0d",
                             $realtime, value, status, occupancy);
                return;
            end
            e = awaited_q.pop_front();
            if (value !== e.value || status !== e.status || occupancy !== e.occupancy) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $realtime, e.value, e.status, e.occupancy,
                             value, status, occupancy);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [2:0]               i_op;
    logic signed [31:0]       i_data_in;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [31:0]       o_value;
    logic [1:0]               o_status;
    logic [OCC_W-1:0]         o_occupancy;

    deque_scoreboard board;
    int unsigned     send_idle_pct;
    int unsigned     take_idle_pct;

    double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stall the response side at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Check every response transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            board.check_result(o_value, o_status, o_occupancy);
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(logic [2:0] op, logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_data_in <= word;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(op, word);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every response is back
    task automatic hold_off();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random op, leaning towards pushes or pops to sweep between empty and full
    function automatic logic [2:0] pick_op(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)
            return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        if (r < 2 + push_pct)
            return $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        case ($urandom_range(3))
            0:       return deq_pkg::OP_POP_FRONT;
            1:       return deq_pkg::OP_POP_BACK;
            2:       return deq_pkg::OP_PEEK_FRONT;
            default: return deq_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    // Random requests in stretches of alternating push or pop bias
    task automatic run_random(int unsigned count);
        int unsigned left;
        int unsigned push_pct;
        left = 0;
        push_pct = 50;
        repeat (count) begin
            if (left == 0) begin
                left = $urandom_range(60, 8);
                push_pct = (push_pct > 50) ? $urandom_range(35, 15) : $urandom_range(85, 60);
            end
            left--;
            send_request(pick_op(push_pct), pick_word());
        end
    endtask

    initial begin
        board         = new();
        send_idle_pct = 7;
        take_idle_pct = 87;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = deq_pkg::OP_PUSH_FRONT;
        i_data_in     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty queue: every read reports empty, spare codes leave the queue unchanged
        send_request(deq_pkg::OP_POP_FRONT, WORD_MAX);
        send_request(deq_pkg::OP_POP_BACK, WORD_MIN);
        send_request(deq_pkg::OP_PEEK_FRONT, '1);
        send_request(deq_pkg::OP_PEEK_BACK, '0);
        send_request(OP_SPARE_LO, WORD_MAX);
        send_request(OP_SPARE_HI, '1);

        // Fill from both ends across the pointer wrap, extremes included
        send_request(deq_pkg::OP_PUSH_FRONT, WORD_MIN);
        send_request(deq_pkg::OP_PUSH_BACK, WORD_MAX);
        send_request(deq_pkg::OP_PUSH_FRONT, '1);
        send_request(deq_pkg::OP_PUSH_BACK, '0);
        for (int i = 0; i < DEPTH - 4; i++)
            send_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, $urandom());

        // Full queue: pushes are refused, reads still see both ends
        send_request(deq_pkg::OP_PUSH_FRONT, WORD_MAX);
        send_request(deq_pkg::OP_PUSH_BACK, WORD_MIN);
        send_request(OP_SPARE_HI, '0);
        send_request(deq_pkg::OP_PEEK_FRONT, '0);
        send_request(deq_pkg::OP_PEEK_BACK, '0);
        send_request(deq_pkg::OP_POP_FRONT, '0);
        send_request(deq_pkg::OP_POP_BACK, '0);

        // Quick sender, stalling receiver
        run_random(270);
        hold_off();

        // Stalling sender, quick receiver
        send_idle_pct = 87;
        take_idle_pct = 7;
        run_random(270);
        hold_off();

        // No idling on either side
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_random(260);
        hold_off();
        repeat (6) @(negedge i_clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: double_ended_queue.f
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue.sv
bench/double_ended_queue_test.sv
